### rtl/lfad_pkg.sv
`timescale 1ns / 1ps

package lfad_pkg;

   // Field widths of the stream and the configuration registers.
   localparam int BYTE_W   = 8;
   localparam int LEN_W    = 27;
   localparam int NAME_W   = 16;
   localparam int HALF_W   = 16;
   localparam int SUM_W    = 32;
   localparam int REGION_W = 3;
   localparam int STATUS_W = 2;
   localparam int PHASE_W  = 3;
   localparam int COUNT_W  = 2;
   localparam int CSR_IDX_W = 1;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_LEN = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_LEN = 1'd1;

   localparam logic [LEN_W-1:0] MIN_LEN_RESET = 27'd10;
   localparam logic [LEN_W-1:0] MAX_LEN_RESET = 27'd67108864;
   localparam logic [LEN_W-1:0] LEN_FLOOR     = 27'd6;

   // Adler-32 modulus and start value of the low sum.
   localparam logic [HALF_W:0]   ADLER_MOD      = 17'd65521;
   localparam logic [HALF_W-1:0] ADLER_LOW_INIT = 16'd1;

   // Parser phases.
   localparam logic [PHASE_W-1:0] PHASE_LEN   = 3'd0;
   localparam logic [PHASE_W-1:0] PHASE_NLEN  = 3'd1;
   localparam logic [PHASE_W-1:0] PHASE_NAME  = 3'd2;
   localparam logic [PHASE_W-1:0] PHASE_BODY  = 3'd3;
   localparam logic [PHASE_W-1:0] PHASE_TRAIL = 3'd4;

   // Region tags on the result channel.
   localparam logic [REGION_W-1:0] REGION_LEN     = 3'd0;
   localparam logic [REGION_W-1:0] REGION_NLEN    = 3'd1;
   localparam logic [REGION_W-1:0] REGION_NAME    = 3'd2;
   localparam logic [REGION_W-1:0] REGION_BODY    = 3'd3;
   localparam logic [REGION_W-1:0] REGION_TRAIL   = 3'd4;
   localparam logic [REGION_W-1:0] REGION_DISCARD = 3'd5;

   // Frame status codes.
   localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_BAD_LEN  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_BAD_SUM  = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_BAD_NAME = 2'd3;

   // Checksum control from the parser.
   typedef struct packed {
      logic clear;
      logic add;
   } sum_ctl_type;

endpackage

### rtl/lfad_checksum.sv
`timescale 1ns / 1ps

module lfad_checksum (
   input  logic                        clock,
   input  logic                        reset,
   input  lfad_pkg::sum_ctl_type       ctl,
   input  logic [lfad_pkg::BYTE_W-1:0] data_byte,
   output logic [lfad_pkg::SUM_W-1:0]  sum
);
   import lfad_pkg::*;

   logic [HALF_W-1:0] low_ff, low_in;
   logic [HALF_W-1:0] high_ff, high_in;
   logic [HALF_W:0]   low_add;
   logic [HALF_W-1:0] low_next;
   logic [HALF_W:0]   high_add;
   logic [HALF_W-1:0] high_next;

   // Both running sums stay below the modulus, so one conditional subtract
   // brings each add back into range.
   always_comb begin
      low_add  = {1'b0, low_ff} + {{(HALF_W+1-BYTE_W){1'b0}}, data_byte};
      low_next = (low_add >= ADLER_MOD) ? HALF_W'(low_add - ADLER_MOD) : low_add[HALF_W-1:0];
      high_add = {1'b0, high_ff} + {1'b0, low_next};
      high_next = (high_add >= ADLER_MOD) ? HALF_W'(high_add - ADLER_MOD)
                                          : high_add[HALF_W-1:0];
      low_in  = low_ff;
      high_in = high_ff;
      if (ctl.clear) begin
         low_in  = ADLER_LOW_INIT;
         high_in = '0;
      end else if (ctl.add) begin
         low_in  = low_next;
         high_in = high_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         low_ff  <= ADLER_LOW_INIT;
         high_ff <= '0;
      end else begin
         low_ff  <= low_in;
         high_ff <= high_in;
      end
   end

   assign sum = {high_ff, low_ff};

endmodule

### rtl/lfad_parser.sv
`timescale 1ns / 1ps

module lfad_parser (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          step,
   input  logic [lfad_pkg::BYTE_W-1:0]   data_byte,
   input  logic                          restart,
   input  logic [lfad_pkg::LEN_W-1:0]    min_len,
   input  logic [lfad_pkg::LEN_W-1:0]    max_len,
   input  logic [lfad_pkg::SUM_W-1:0]    sum,
   output lfad_pkg::sum_ctl_type         ctl,
   output logic [lfad_pkg::REGION_W-1:0] region,
   output logic                          frame_end,
   output logic [lfad_pkg::STATUS_W-1:0] status,
   output logic                          halted
);
   import lfad_pkg::*;

   logic [PHASE_W-1:0] phase_ff, phase_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [LEN_W-1:0]   length_ff, length_in;
   logic [LEN_W-1:0]   left_ff, left_in;
   logic [NAME_W-1:0]  name_ff, name_in;
   logic [SUM_W-1:0]   expect_ff, expect_in;
   logic               stopped_ff, stopped_in;
   logic               overflow_ff, overflow_in;
   logic               name_bad_ff, name_bad_in;

   logic [LEN_W-1:0]   length_shift;
   logic [LEN_W-1:0]   min_eff;
   logic [NAME_W-1:0]  name_shift;
   logic [NAME_W-1:0]  name_dec;
   logic [LEN_W-1:0]   left_dec;
   logic [SUM_W-1:0]   expect_shift;
   logic               clear_frame;
   logic               add_byte;

   always_comb begin
      length_shift = {length_ff[LEN_W-BYTE_W-1:0], data_byte};
      min_eff      = (min_len < LEN_FLOOR) ? LEN_FLOOR : min_len;
      name_shift   = {name_ff[NAME_W-BYTE_W-1:0], data_byte};
      name_dec     = (name_ff != '0) ? name_ff - NAME_W'(1) : name_ff;
      left_dec     = (left_ff != '0) ? left_ff - LEN_W'(1) : left_ff;
      expect_shift = {expect_ff[SUM_W-BYTE_W-1:0], data_byte};

      phase_in    = phase_ff;
      count_in    = count_ff;
      length_in   = length_ff;
      left_in     = left_ff;
      name_in     = name_ff;
      expect_in   = expect_ff;
      stopped_in  = stopped_ff;
      overflow_in = overflow_ff;
      name_bad_in = name_bad_ff;
      clear_frame = 1'b0;
      add_byte    = 1'b0;
      region      = REGION_DISCARD;
      frame_end   = 1'b0;
      status      = STATUS_OK;

      if (restart) begin
         clear_frame = 1'b1;
         stopped_in  = 1'b0;
      end else if (!stopped_ff) begin
         unique case (phase_ff)
            PHASE_LEN: begin
               region    = REGION_LEN;
               length_in = length_shift;
               // The first length byte carries bits 31..24; anything above
               // bit 26 makes the length too large.
               if (count_ff == '0 && data_byte[BYTE_W-1:LEN_W-24] != '0) begin
                  overflow_in = 1'b1;
               end
               if (count_ff == 2'd3) begin
                  if (overflow_ff || length_shift > max_len || length_shift < min_eff) begin
                     frame_end  = 1'b1;
                     status     = STATUS_BAD_LEN;
                     stopped_in = 1'b1;
                  end else begin
                     left_in  = length_shift - LEN_FLOOR;
                     phase_in = PHASE_NLEN;
                     count_in = '0;
                     name_in  = '0;
                  end
               end else begin
                  count_in = count_ff + COUNT_W'(1);
               end
            end
            PHASE_NLEN: begin
               region   = REGION_NLEN;
               add_byte = 1'b1;
               name_in  = name_shift;
               if (count_ff == 2'd1) begin
                  count_in = '0;
                  if (name_shift >= NAME_W'(2) &&
                      {{(LEN_W-NAME_W){1'b0}}, name_shift} <= left_ff) begin
                     phase_in = PHASE_NAME;
                  end else begin
                     // A bad name length turns the whole payload into body.
                     name_bad_in = 1'b1;
                     name_in     = '0;
                     phase_in    = (left_ff != '0) ? PHASE_BODY : PHASE_TRAIL;
                  end
               end else begin
                  count_in = 2'd1;
               end
            end
            PHASE_NAME: begin
               region   = REGION_NAME;
               add_byte = 1'b1;
               name_in  = name_dec;
               left_in  = left_dec;
               if (name_dec == '0) begin
                  phase_in = (left_dec != '0) ? PHASE_BODY : PHASE_TRAIL;
               end
            end
            PHASE_BODY: begin
               region   = REGION_BODY;
               add_byte = 1'b1;
               left_in  = left_dec;
               if (left_dec == '0) begin
                  phase_in = PHASE_TRAIL;
               end
            end
            default: begin
               region    = REGION_TRAIL;
               expect_in = expect_shift;
               if (count_ff == 2'd3) begin
                  frame_end = 1'b1;
                  if (expect_shift != sum) begin
                     status = STATUS_BAD_SUM;
                  end else if (name_bad_ff) begin
                     status = STATUS_BAD_NAME;
                  end else begin
                     status = STATUS_OK;
                  end
                  clear_frame = 1'b1;
                  if (status != STATUS_OK) begin
                     stopped_in = 1'b1;
                  end
               end else begin
                  count_in = count_ff + COUNT_W'(1);
               end
            end
         endcase
      end

      if (clear_frame) begin
         phase_in    = PHASE_LEN;
         count_in    = '0;
         length_in   = '0;
         left_in     = '0;
         name_in     = '0;
         expect_in   = '0;
         overflow_in = 1'b0;
         name_bad_in = 1'b0;
      end

      halted    = stopped_in;
      ctl.clear = step && clear_frame;
      ctl.add   = step && add_byte;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PHASE_LEN;
         count_ff    <= '0;
         length_ff   <= '0;
         left_ff     <= '0;
         name_ff     <= '0;
         expect_ff   <= '0;
         stopped_ff  <= 1'b0;
         overflow_ff <= 1'b0;
         name_bad_ff <= 1'b0;
      end else if (step) begin
         phase_ff    <= phase_in;
         count_ff    <= count_in;
         length_ff   <= length_in;
         left_ff     <= left_in;
         name_ff     <= name_in;
         expect_ff   <= expect_in;
         stopped_ff  <= stopped_in;
         overflow_ff <= overflow_in;
         name_bad_ff <= name_bad_in;
      end
   end

endmodule

### rtl/length_framed_adler32_deframer.sv
`timescale 1ns / 1ps

// Length-framed stream deframer with an Adler-32 trailer check.
// The req channel takes one received byte per item (req_data_byte), or a
// restart item (req_restart high) that clears a halt and any partial frame
// and produces no result. The rsp channel returns one item for every byte:
// the byte itself, its region tag, a frame_end flag with a status on the
// last byte of a frame (or on a rejected length), and the halted flag.
// The csr port writes min_len (index 0) and max_len (index 1); write only
// while the block is idle.
// An accepted item is held in the input register, and its result is loaded
// from there into the result register. Throughput is one item per cycle
// while the receiver does not stall; the per-byte frame parser and the
// Adler-32 update (one add and one conditional subtract per sum) set that
// figure. Restart items are consumed without producing a result.
// Reset (synchronous, active high) empties both registers, restores the
// register defaults and puts the parser at the start of a length header.
// When the receiver stalls, the result register holds its item, the input
// register fills, and req_stall rises until the result is taken.

module length_framed_adler32_deframer (
   input  logic                          clock,
   input  logic                          reset,
   // Input channel.
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [lfad_pkg::BYTE_W-1:0]   req_data_byte,
   input  logic                          req_restart,
   // Result channel.
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [lfad_pkg::BYTE_W-1:0]   rsp_out_byte,
   output logic [lfad_pkg::REGION_W-1:0] rsp_region,
   output logic                          rsp_frame_end,
   output logic [lfad_pkg::STATUS_W-1:0] rsp_status,
   output logic                          rsp_halted,
   // Configuration write port.
   input  logic                          csr_write,
   input  logic [lfad_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [lfad_pkg::LEN_W-1:0]    csr_wdata
);
   import lfad_pkg::*;

   // Configuration registers.
   logic [LEN_W-1:0] min_len_ff, min_len_in;
   logic [LEN_W-1:0] max_len_ff, max_len_in;

   // Input register.
   logic              in_valid_ff, in_valid_in;
   logic [BYTE_W-1:0] in_byte_ff;
   logic              in_restart_ff;

   // Result register.
   logic                out_valid_ff, out_valid_in;
   logic [BYTE_W-1:0]   out_byte_ff;
   logic [REGION_W-1:0] out_region_ff;
   logic                out_frame_end_ff;
   logic [STATUS_W-1:0] out_status_ff;
   logic                out_halted_ff;

   logic                req_take;
   logic                rsp_take;
   logic                step;
   logic                emit;
   sum_ctl_type         sum_ctl;
   logic [SUM_W-1:0]    sum;
   logic [REGION_W-1:0] region;
   logic                frame_end;
   logic [STATUS_W-1:0] status;
   logic                halted;

   always_comb begin
      min_len_in = min_len_ff;
      max_len_in = max_len_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_MIN_LEN: min_len_in = csr_wdata;
            CSR_MAX_LEN: max_len_in = csr_wdata;
            default:     min_len_in = min_len_ff;
         endcase
      end
   end

   // The held item advances when it is a restart (no result to place) or
   // when the result register is empty or being emptied this cycle.
   assign rsp_take  = out_valid_ff && !rsp_stall;
   assign step      = in_valid_ff && (in_restart_ff || !out_valid_ff || !rsp_stall);
   assign emit      = step && !in_restart_ff;
   assign req_stall = in_valid_ff && !step;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (step) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (emit) begin
         out_valid_in = 1'b1;
      end else if (rsp_take) begin
         out_valid_in = 1'b0;
      end
   end

   lfad_checksum u_checksum (
      .clock     (clock),
      .reset     (reset),
      .ctl       (sum_ctl),
      .data_byte (in_byte_ff),
      .sum       (sum)
   );

   lfad_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .data_byte (in_byte_ff),
      .restart   (in_restart_ff),
      .min_len   (min_len_ff),
      .max_len   (max_len_ff),
      .sum       (sum),
      .ctl       (sum_ctl),
      .region    (region),
      .frame_end (frame_end),
      .status    (status),
      .halted    (halted)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         min_len_ff   <= MIN_LEN_RESET;
         max_len_ff   <= MAX_LEN_RESET;
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         min_len_ff   <= min_len_in;
         max_len_ff   <= max_len_in;
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers load without reset.
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff    <= req_data_byte;
         in_restart_ff <= req_restart;
      end
      if (emit) begin
         out_byte_ff      <= in_byte_ff;
         out_region_ff    <= region;
         out_frame_end_ff <= frame_end;
         out_status_ff    <= status;
         out_halted_ff    <= halted;
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_out_byte  = out_byte_ff;
   assign rsp_region    = out_region_ff;
   assign rsp_frame_end = out_frame_end_ff;
   assign rsp_status    = out_status_ff;
   assign rsp_halted    = out_halted_ff;

`ifndef SYNTHESIS
   // A status other than ok only appears on the last byte of a frame.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_frame_end || rsp_status == STATUS_OK))
      else $error("status set without frame_end");

   // Discarded bytes are only tagged while halted, and never end a frame.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_region == REGION_DISCARD) |-> (rsp_halted && !rsp_frame_end))
      else $error("discarded byte while not halted");

   // Every failing frame leaves the block halted.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_frame_end && rsp_status != STATUS_OK) |-> rsp_halted)
      else $error("frame error without halt");

   // The input side only stalls while the input register holds an item.
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (in_valid_ff && out_valid_ff && !in_restart_ff))
      else $error("stall with free input register");
`endif

endmodule
